[src/tlpq_pkg.sv]
// ----------------------------------------------------------------------------
// tlpq_pkg
// shared types and constants of the two level priority queue with aging
// ----------------------------------------------------------------------------
package tlpq_pkg;

  localparam int unsigned FIFO_DEPTH_DEFAULT = 16;
  localparam int unsigned ID_W               = 32;
  localparam int unsigned TICK_W             = 32;
  localparam int unsigned APB_ADDR_W         = 3;
  localparam int unsigned APB_DATA_W         = 32;

  localparam logic [TICK_W-1:0] STARVATION_RESET = 32'd6000;

  // register index taken from paddr[2]
  localparam logic REG_STARVATION = 1'b0;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_INSERT  = 2'd1,
    CMD_EXTRACT = 2'd2
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic empty_next;
  } fifo_stat_t;

endpackage

[src/tlpq_fifo.sv]
// ----------------------------------------------------------------------------
// tlpq_fifo
// circular buffer with registered read and a prefetched head word
// ----------------------------------------------------------------------------
module tlpq_fifo #(
  parameter int unsigned DEPTH = tlpq_pkg::FIFO_DEPTH_DEFAULT,
  parameter int unsigned WIDTH = tlpq_pkg::ID_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 pop,
  input  logic [WIDTH-1:0]     wdata,
  output logic [WIDTH-1:0]     head_data,
  output tlpq_pkg::fifo_stat_t stat
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [WIDTH-1:0] rd_data;
  logic [WIDTH-1:0] byp_data;
  logic             byp_valid;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] tail_inc;
  logic [PTR_W-1:0] rd_addr;
  logic             collide;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head_inc = ptr_inc(head);
  assign tail_inc = ptr_inc(tail);
  assign rd_addr  = pop ? head_inc : head;
  // write lands on the word being read this cycle
  assign collide  = push && (count == '0);

  always_comb begin
    count_next = count;
    if (push) begin
      count_next = count + CNT_W'(1);
    end else if (pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      byp_valid <= 1'b0;
    end else begin
      count     <= count_next;
      byp_valid <= collide;
      if (push) begin
        tail <= tail_inc;
      end
      if (pop) begin
        head <= head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= wdata;
    end
    rd_data <= mem[rd_addr];
    if (collide) begin
      byp_data <= wdata;
    end
  end

  assign head_data       = byp_valid ? byp_data : rd_data;
  assign stat.empty      = (count == '0);
  assign stat.full       = (count == CNT_W'(DEPTH));
  assign stat.empty_next = (count_next == '0);

endmodule

[src/tlpq_apb.sv]
// ----------------------------------------------------------------------------
// tlpq_apb
// configuration register file behind the apb port
// ----------------------------------------------------------------------------
module tlpq_apb (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tlpq_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tlpq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tlpq_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [tlpq_pkg::TICK_W-1:0]         starvation_ticks
);

  logic wr_en;
  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == tlpq_pkg::REG_STARVATION);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      starvation_ticks <= tlpq_pkg::STARVATION_RESET;
    end else if (wr_en && hit) begin
      starvation_ticks <= pwdata;
    end
  end

  assign prdata = hit ? starvation_ticks : '0;

endmodule

[src/two_level_priority_queue_aging.sv]
// ----------------------------------------------------------------------------
// two_level_priority_queue_aging
// high and low priority id queues with a tick counter; the oldest low entry
// overtakes high entries once it has waited the starvation threshold
// ----------------------------------------------------------------------------
// result: registered in the output register in the cycle after the input transfer
// throughput: one item per cycle, set by the single head read of each queue
// and the output register, which accepts while empty or while its result is being taken
// reset: synchronous, clears pointers, counts, tick counter and output valid;
// threshold returns to 6000, queue storage is not cleared
module two_level_priority_queue_aging #(
  parameter int unsigned FIFO_DEPTH = tlpq_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      cmd,
  input  logic [tlpq_pkg::ID_W-1:0]       packet_id,
  input  logic                            high_priority,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            found,
  output logic [tlpq_pkg::ID_W-1:0]       out_id,
  output logic                            out_high,
  output logic                            by_aging,
  output logic                            dropped,
  output logic                            all_empty,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlpq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tlpq_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tlpq_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int unsigned ID_W   = tlpq_pkg::ID_W;
  localparam int unsigned TICK_W = tlpq_pkg::TICK_W;
  localparam int unsigned LOW_W  = TICK_W + ID_W;

  logic                   accept;
  logic [TICK_W-1:0]      tick_now;
  logic [TICK_W-1:0]      starvation_ticks;
  logic [TICK_W-1:0]      waited;
  logic [ID_W-1:0]        high_head;
  logic [LOW_W-1:0]       low_head;
  tlpq_pkg::fifo_stat_t   high_stat;
  tlpq_pkg::fifo_stat_t   low_stat;
  logic                   high_push;
  logic                   high_pop;
  logic                   low_push;
  logic                   low_pop;
  logic                   do_tick;
  logic                   force_low;
  logic                   found_next;
  logic [ID_W-1:0]        out_id_next;
  logic                   out_high_next;
  logic                   by_aging_next;
  logic                   dropped_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  tlpq_apb u_apb (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .starvation_ticks (starvation_ticks)
  );

  tlpq_fifo #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (ID_W)
  ) u_high (
    .clk       (clk),
    .rst       (rst),
    .push      (high_push),
    .pop       (high_pop),
    .wdata     (packet_id),
    .head_data (high_head),
    .stat      (high_stat)
  );

  tlpq_fifo #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (LOW_W)
  ) u_low (
    .clk       (clk),
    .rst       (rst),
    .push      (low_push),
    .pop       (low_pop),
    .wdata     ({tick_now, packet_id}),
    .head_data (low_head),
    .stat      (low_stat)
  );

  // wrapping wait of the oldest low entry
  assign waited    = tick_now - low_head[LOW_W-1:ID_W];
  assign force_low = !low_stat.empty && (waited >= starvation_ticks);

  always_comb begin
    high_push     = 1'b0;
    high_pop      = 1'b0;
    low_push      = 1'b0;
    low_pop       = 1'b0;
    do_tick       = 1'b0;
    found_next    = 1'b0;
    out_id_next   = '0;
    out_high_next = 1'b0;
    by_aging_next = 1'b0;
    dropped_next  = 1'b0;
    if (accept) begin
      case (tlpq_pkg::cmd_t'(cmd))
        tlpq_pkg::CMD_TICK: begin
          do_tick = 1'b1;
        end
        tlpq_pkg::CMD_INSERT: begin
          if (high_priority) begin
            if (high_stat.full) begin
              dropped_next = 1'b1;
            end else begin
              high_push = 1'b1;
            end
          end else begin
            if (low_stat.full) begin
              dropped_next = 1'b1;
            end else begin
              low_push = 1'b1;
            end
          end
        end
        tlpq_pkg::CMD_EXTRACT: begin
          if (force_low || (high_stat.empty && !low_stat.empty)) begin
            low_pop       = 1'b1;
            found_next    = 1'b1;
            out_id_next   = low_head[ID_W-1:0];
            by_aging_next = force_low;
          end else if (!high_stat.empty) begin
            high_pop      = 1'b1;
            found_next    = 1'b1;
            out_id_next   = high_head;
            out_high_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (do_tick) begin
        tick_now <= tick_now + TICK_W'(1);
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found     <= found_next;
      out_id    <= out_id_next;
      out_high  <= out_high_next;
      by_aging  <= by_aging_next;
      dropped   <= dropped_next;
      all_empty <= high_stat.empty_next && low_stat.empty_next;
    end
  end

endmodule
